// ===== design/ldl3_pkg.sv =====
`default_nettype none

package ldl3_pkg;

  // working format: signed, input fraction bits, saturated to +-(2^62 - 1)
  typedef logic signed [63:0] work_t;

  localparam work_t WORK_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  // quotient bits below the overflow point of a division
  localparam int QBITS = 63;

  function automatic work_t wsub(work_t a, work_t b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    s   = {a[63], a} - {b[63], b};
    lim = {WORK_MAX[63], WORK_MAX};
    if (s > lim) begin
      return WORK_MAX;
    end else if (s < -lim) begin
      return -WORK_MAX;
    end
    return s[63:0];
  endfunction

  // zero or negative pivot
  function automatic logic nonpos(work_t v);
    return v[63] | (v == '0);
  endfunction

endpackage

`default_nettype wire

// ===== design/ldl3_div.sv =====
`default_nettype none

module ldl3_div #(
  parameter int FRAC   = 28,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  ldl3_pkg::work_t        d_i,
  input  ldl3_pkg::work_t        n_i [LANES],
  input  wire [SIDE_W-1:0]       side_i,
  output logic                   valid_o,
  output ldl3_pkg::work_t        q_o [LANES],
  output logic [SIDE_W-1:0]      side_o
);
  import ldl3_pkg::*;

  localparam int STEPS = QBITS;

  logic [STEPS+1:0]   vld_q;
  work_t              d_q    [STEPS+1];
  logic [SIDE_W-1:0]  side_q [STEPS+1];
  logic [63:0]        rem_q  [STEPS+1][LANES];
  logic [QBITS-1:0]   w_q    [STEPS+1][LANES];
  logic               neg_q  [STEPS+1][LANES];
  logic               ovf_q  [STEPS+1][LANES];

  logic [63:0]        un     [LANES];
  logic [127:0]       nn     [LANES];
  logic [64:0]        hi     [LANES];
  logic [64:0]        tr     [STEPS][LANES];
  logic               ge     [STEPS][LANES];
  logic [63:0]        nrem   [STEPS][LANES];
  logic               up     [LANES];
  logic [63:0]        qr     [LANES];
  work_t              qf     [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      un[l] = n_i[l][63] ? 64'(-n_i[l]) : n_i[l];
      nn[l] = {64'd0, un[l]} << FRAC;
      hi[l] = nn[l][127:QBITS];
    end
    // one quotient bit per stage, restoring
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        tr[s][l]   = {rem_q[s][l], w_q[s][l][QBITS-1]};
        ge[s][l]   = tr[s][l] >= {1'b0, d_q[s]};
        nrem[s][l] = ge[s][l] ? 64'(tr[s][l] - {1'b0, d_q[s]}) : tr[s][l][63:0];
      end
    end
    // round half away from zero, then saturate
    for (int l = 0; l < LANES; l++) begin
      up[l] = {rem_q[STEPS][l], 1'b0} >= {1'b0, d_q[STEPS]};
      qr[l] = {1'b0, w_q[STEPS][l]} + 64'(up[l]);
      if (ovf_q[STEPS][l] || (qr[l] > 64'(WORK_MAX))) begin
        qf[l] = neg_q[STEPS][l] ? -WORK_MAX : WORK_MAX;
      end else begin
        qf[l] = neg_q[STEPS][l] ? -work_t'(qr[l]) : work_t'(qr[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]    <= d_i;
      side_q[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        neg_q[0][l] <= n_i[l][63];
        rem_q[0][l] <= hi[l][63:0];
        w_q[0][l]   <= nn[l][QBITS-1:0];
        ovf_q[0][l] <= hi[l] >= {1'b0, d_i};
      end
      for (int s = 1; s <= STEPS; s++) begin
        d_q[s]    <= d_q[s-1];
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
          rem_q[s][l] <= nrem[s-1][l];
          w_q[s][l]   <= {w_q[s-1][l][QBITS-2:0], ge[s-1][l]};
        end
      end
      side_o <= side_q[STEPS];
      for (int l = 0; l < LANES; l++) begin
        q_o[l] <= qf[l];
      end
    end
  end

  assign valid_o = vld_q[STEPS+1];

  // restoring division keeps the remainder below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STEPS] && !ovf_q[STEPS][0] |-> rem_q[STEPS][0] < d_q[STEPS])
    else $error("remainder not below divisor");

  a_rem0_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !ovf_q[0][0] |-> rem_q[0][0] < d_q[0])
    else $error("start remainder not below divisor");

endmodule

`default_nettype wire

// ===== design/ldl3_mul.sv =====
`default_nettype none

module ldl3_mul #(
  parameter int FRAC   = 28,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  ldl3_pkg::work_t        a_i [LANES],
  input  ldl3_pkg::work_t        b_i [LANES],
  input  wire [SIDE_W-1:0]       side_i,
  output logic                   valid_o,
  output ldl3_pkg::work_t        p_o [LANES],
  output logic [SIDE_W-1:0]      side_o
);
  import ldl3_pkg::*;

  localparam logic [127:0] RND = 128'd1 << (FRAC - 1);

  logic [2:0]         vld_q;
  logic [SIDE_W-1:0]  side_q [2];
  logic               neg_q  [2][LANES];
  logic [63:0]        pp_q   [LANES][4];
  logic [127:0]       prod_q [LANES];

  logic [63:0]        ua     [LANES];
  logic [63:0]        ub     [LANES];
  logic [127:0]       sh     [LANES];
  work_t              pf     [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ua[l] = a_i[l][63] ? 64'(-a_i[l]) : a_i[l];
      ub[l] = b_i[l][63] ? 64'(-b_i[l]) : b_i[l];
      sh[l] = (prod_q[l] + RND) >> FRAC;
      if (sh[l] > {64'd0, WORK_MAX}) begin
        pf[l] = neg_q[1][l] ? -WORK_MAX : WORK_MAX;
      end else begin
        pf[l] = neg_q[1][l] ? -work_t'(sh[l][63:0]) : work_t'(sh[l][63:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_o    <= side_q[1];
      for (int l = 0; l < LANES; l++) begin
        // 32x32 partial products
        neg_q[0][l] <= a_i[l][63] ^ b_i[l][63];
        pp_q[l][0]  <= ua[l][31:0]  * ub[l][31:0];
        pp_q[l][1]  <= ua[l][31:0]  * ub[l][63:32];
        pp_q[l][2]  <= ua[l][63:32] * ub[l][31:0];
        pp_q[l][3]  <= ua[l][63:32] * ub[l][63:32];
        neg_q[1][l] <= neg_q[0][l];
        prod_q[l]   <= {pp_q[l][3], 64'd0} + {32'd0, pp_q[l][1], 32'd0}
                     + {32'd0, pp_q[l][2], 32'd0} + {64'd0, pp_q[l][0]};
        p_o[l]      <= pf[l];
      end
    end
  end

  assign valid_o = vld_q[2];

  // operands stay below 2^63 in magnitude
  a_prod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> prod_q[0][127:126] == 2'b00)
    else $error("product out of range");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && vld_q[1] |=> vld_q[2])
    else $error("product stage lost a word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("stage moved while stalled");

endmodule

`default_nettype wire

// ===== design/symmetric_3x3_ldl_solver_unit.sv =====
`default_nettype none

// symmetric 3x3 LDL solver, one pixel per word
//
// s_axis carries one word per pixel: six upper-triangle entries of A and the
// right-hand side b, signed Q4.(IN_WIDTH-4). m_axis returns x with A x = b as
// three signed Q16.(OUT_WIDTH-16) values, saturated, and tuser = singular.
// a zero or negative pivot forces the solution to zero and sets tuser.
//
// throughput: one word per cycle while the pipeline is not frozen by a held output word.
// the pipeline is made of three 65-stage dividers in series (one quotient bit
// per stage: pivot d1, then d2, then d3), plus 3-stage 64x64 multipliers and
// single subtract stages.
//
// the whole pipeline advances together; when the output word is held and
// m_axis_tready is low, every stage freezes and s_axis_tready drops, so no
// word is lost or repeated. words behind the output keep their places.
// reset clears the valid bits only; the pipeline then reads empty and
// s_axis_tready is high.
module symmetric_3x3_ldl_solver_unit #(
  parameter int IN_WIDTH  = 32,
  parameter int OUT_WIDTH = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // a11, a12, a13, a22, a23, a33, rhs1, rhs2, rhs3
  input  wire [((9*IN_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // sol1, sol2, sol3
  output logic [((3*OUT_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // singular
  output logic                               m_axis_tuser
);
  import ldl3_pkg::*;

  localparam int FRAC   = IN_WIDTH - 4;
  localparam int OFRAC  = OUT_WIDTH - 16;
  localparam int DIFF   = FRAC - OFRAC;
  localparam int SHR    = (DIFF > 0) ? DIFF : 0;
  localparam int SHR_M1 = (DIFF > 0) ? DIFF - 1 : 0;
  localparam int SHL    = (DIFF < 0) ? -DIFF : 0;
  localparam int OUT_DW = ((3*OUT_WIDTH+7)/8)*8;
  localparam logic [63:0] RND  = (DIFF > 0) ? (64'd1 << SHR_M1) : 64'd0;
  localparam logic [63:0] LIM  = (64'd1 << 62) >> SHL;
  localparam logic [63:0] OTOP = 64'd1 << (OUT_WIDTH - 1);

  // side data carried along each unit
  typedef struct packed {
    logic sing; work_t a12, a13, a22, a23, a33, b1, b2, b3;
  } a_side_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, a22, a23, a33, b2, b3;
  } b_side_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, d2, t, s1, y2, y3a;
  } c_reg_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, d2, s1, y2, y3a;
  } d_side_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, d2, s1, y3a, l23, q2;
  } e_side_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, s1, y3, l23, q2;
  } f_side_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, d3, y3, l23, q2;
  } g_reg_t;
  typedef struct packed {
    logic sing; work_t l12, l13, q1, l23, q2;
  } h_side_t;
  typedef struct packed {
    logic sing; work_t l12, q1, q2, x3;
  } i_side_t;
  typedef struct packed {
    logic sing; work_t l12, q1, x2, x3, m11;
  } j_reg_t;
  typedef struct packed {
    logic sing; work_t q1, x2, x3, m11;
  } k_side_t;
  typedef struct packed {
    logic sing; work_t x1, x2, x3;
  } l_reg_t;

  function automatic logic [OUT_WIDTH-1:0] to_out(work_t v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : v;
    if (DIFF > 0) begin
      m = (m + RND) >> SHR;
    end else if (DIFF < 0) begin
      m = (m > LIM) ? (64'd1 << 62) : (m << SHL);
    end
    if (v[63]) begin
      if (m > OTOP) m = OTOP;
      return OUT_WIDTH'(-m);
    end
    if (m > OTOP - 64'd1) m = OTOP - 64'd1;
    return OUT_WIDTH'(m);
  endfunction

  // global advance: the output register is free or being taken
  logic en;
  logic out_vld_q;
  assign en            = m_axis_tready | ~out_vld_q;
  assign s_axis_tready = en;

  logic signed [IN_WIDTH-1:0] fin [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      fin[k] = s_axis_tdata[k*IN_WIDTH +: IN_WIDTH];
    end
  end

  // pivot d1: l12, l13 and y1/d1 share the divisor a11
  a_side_t a_si, a_so;
  work_t   a_n [3];
  work_t   a_q [3];
  logic    a_vld;
  assign a_si = '{sing: nonpos(work_t'(fin[0])),
                  a12: work_t'(fin[1]), a13: work_t'(fin[2]), a22: work_t'(fin[3]),
                  a23: work_t'(fin[4]), a33: work_t'(fin[5]), b1: work_t'(fin[6]),
                  b2: work_t'(fin[7]), b3: work_t'(fin[8])};
  assign a_n = '{work_t'(fin[1]), work_t'(fin[2]), work_t'(fin[6])};

  ldl3_div #(.FRAC(FRAC), .LANES(3), .SIDE_W($bits(a_side_t))) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .d_i(work_t'(fin[0])), .n_i(a_n), .side_i(a_si),
    .valid_o(a_vld), .q_o(a_q), .side_o(a_so)
  );

  // products with l12, l13
  b_side_t b_si, b_so;
  work_t   b_a [5];
  work_t   b_b [5];
  work_t   b_p [5];
  logic    b_vld;
  assign b_si = '{sing: a_so.sing, l12: a_q[0], l13: a_q[1], q1: a_q[2],
                  a22: a_so.a22, a23: a_so.a23, a33: a_so.a33, b2: a_so.b2, b3: a_so.b3};
  assign b_a = '{a_q[0], a_q[1], a_q[1], a_q[0], a_q[1]};
  assign b_b = '{a_so.a12, a_so.a12, a_so.a13, a_so.b1, a_so.b1};

  ldl3_mul #(.FRAC(FRAC), .LANES(5), .SIDE_W($bits(b_side_t))) u_mul_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_vld),
    .a_i(b_a), .b_i(b_b), .side_i(b_si),
    .valid_o(b_vld), .p_o(b_p), .side_o(b_so)
  );

  // pivot d2 and the partial sums
  c_reg_t c_d, c_q;
  logic   c_vld_q;
  always_comb begin
    c_d      = '{sing: b_so.sing, l12: b_so.l12, l13: b_so.l13, q1: b_so.q1,
                 d2: wsub(b_so.a22, b_p[0]), t: wsub(b_so.a23, b_p[1]),
                 s1: wsub(b_so.a33, b_p[2]), y2: wsub(b_so.b2, b_p[3]),
                 y3a: wsub(b_so.b3, b_p[4])};
    c_d.sing = b_so.sing | nonpos(c_d.d2);
  end

  // pivot d2 divisions: l23 and y2/d2
  d_side_t d_si, d_so;
  work_t   d_n [2];
  work_t   d_q [2];
  logic    d_vld;
  assign d_si = '{sing: c_q.sing, l12: c_q.l12, l13: c_q.l13, q1: c_q.q1,
                  d2: c_q.d2, s1: c_q.s1, y2: c_q.y2, y3a: c_q.y3a};
  assign d_n = '{c_q.t, c_q.y2};

  ldl3_div #(.FRAC(FRAC), .LANES(2), .SIDE_W($bits(d_side_t))) u_div_d (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_vld_q),
    .d_i(c_q.d2), .n_i(d_n), .side_i(d_si),
    .valid_o(d_vld), .q_o(d_q), .side_o(d_so)
  );

  // l23*l23 and l23*y2
  e_side_t e_si, e_so;
  work_t   e_a [2];
  work_t   e_b [2];
  work_t   e_p [2];
  logic    e_vld;
  assign e_si = '{sing: d_so.sing, l12: d_so.l12, l13: d_so.l13, q1: d_so.q1,
                  d2: d_so.d2, s1: d_so.s1, y3a: d_so.y3a, l23: d_q[0], q2: d_q[1]};
  assign e_a = '{d_q[0], d_q[0]};
  assign e_b = '{d_q[0], d_so.y2};

  ldl3_mul #(.FRAC(FRAC), .LANES(2), .SIDE_W($bits(e_side_t))) u_mul_e (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_vld),
    .a_i(e_a), .b_i(e_b), .side_i(e_si),
    .valid_o(e_vld), .p_o(e_p), .side_o(e_so)
  );

  // l23^2 * d2, y3 alongside
  f_side_t f_si, f_so;
  work_t   f_a [1];
  work_t   f_b [1];
  work_t   f_p [1];
  logic    f_vld;
  assign f_si = '{sing: e_so.sing, l12: e_so.l12, l13: e_so.l13, q1: e_so.q1,
                  s1: e_so.s1, y3: wsub(e_so.y3a, e_p[1]), l23: e_so.l23, q2: e_so.q2};
  assign f_a = '{e_p[0]};
  assign f_b = '{e_so.d2};

  ldl3_mul #(.FRAC(FRAC), .LANES(1), .SIDE_W($bits(f_side_t))) u_mul_f (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_vld),
    .a_i(f_a), .b_i(f_b), .side_i(f_si),
    .valid_o(f_vld), .p_o(f_p), .side_o(f_so)
  );

  // pivot d3
  g_reg_t g_d, g_q;
  logic   g_vld_q;
  always_comb begin
    g_d      = '{sing: f_so.sing, l12: f_so.l12, l13: f_so.l13, q1: f_so.q1,
                 d3: wsub(f_so.s1, f_p[0]), y3: f_so.y3, l23: f_so.l23, q2: f_so.q2};
    g_d.sing = f_so.sing | nonpos(g_d.d3);
  end

  // x3 = y3/d3
  h_side_t h_si, h_so;
  work_t   h_n [1];
  work_t   h_q [1];
  logic    h_vld;
  assign h_si = '{sing: g_q.sing, l12: g_q.l12, l13: g_q.l13, q1: g_q.q1,
                  l23: g_q.l23, q2: g_q.q2};
  assign h_n = '{g_q.y3};

  ldl3_div #(.FRAC(FRAC), .LANES(1), .SIDE_W($bits(h_side_t))) u_div_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_vld_q),
    .d_i(g_q.d3), .n_i(h_n), .side_i(h_si),
    .valid_o(h_vld), .q_o(h_q), .side_o(h_so)
  );

  // l23*x3 and l13*x3
  i_side_t i_si, i_so;
  work_t   i_a [2];
  work_t   i_b [2];
  work_t   i_p [2];
  logic    i_vld;
  assign i_si = '{sing: h_so.sing, l12: h_so.l12, q1: h_so.q1, q2: h_so.q2, x3: h_q[0]};
  assign i_a = '{h_so.l23, h_so.l13};
  assign i_b = '{h_q[0], h_q[0]};

  ldl3_mul #(.FRAC(FRAC), .LANES(2), .SIDE_W($bits(i_side_t))) u_mul_i (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_vld),
    .a_i(i_a), .b_i(i_b), .side_i(i_si),
    .valid_o(i_vld), .p_o(i_p), .side_o(i_so)
  );

  // x2
  j_reg_t j_d, j_q;
  logic   j_vld_q;
  assign j_d = '{sing: i_so.sing, l12: i_so.l12, q1: i_so.q1,
                 x2: wsub(i_so.q2, i_p[0]), x3: i_so.x3, m11: i_p[1]};

  // l12*x2
  k_side_t k_si, k_so;
  work_t   k_a [1];
  work_t   k_b [1];
  work_t   k_p [1];
  logic    k_vld;
  assign k_si = '{sing: j_q.sing, q1: j_q.q1, x2: j_q.x2, x3: j_q.x3, m11: j_q.m11};
  assign k_a = '{j_q.l12};
  assign k_b = '{j_q.x2};

  ldl3_mul #(.FRAC(FRAC), .LANES(1), .SIDE_W($bits(k_side_t))) u_mul_k (
    .clk_i, .rst_ni, .en_i(en), .valid_i(j_vld_q),
    .a_i(k_a), .b_i(k_b), .side_i(k_si),
    .valid_o(k_vld), .p_o(k_p), .side_o(k_so)
  );

  // x1, subtracted in model order
  l_reg_t l_d, l_q;
  logic   l_vld_q;
  assign l_d = '{sing: k_so.sing, x1: wsub(wsub(k_so.q1, k_p[0]), k_so.m11),
                 x2: k_so.x2, x3: k_so.x3};

  // output register
  logic [OUT_WIDTH-1:0] sol_d [3];
  logic [OUT_WIDTH-1:0] sol_q [3];
  logic                 sing_q;
  always_comb begin
    sol_d[0] = l_q.sing ? '0 : to_out(l_q.x1);
    sol_d[1] = l_q.sing ? '0 : to_out(l_q.x2);
    sol_d[2] = l_q.sing ? '0 : to_out(l_q.x3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      j_vld_q   <= 1'b0;
      l_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q   <= b_vld;
      g_vld_q   <= f_vld;
      j_vld_q   <= i_vld;
      l_vld_q   <= k_vld;
      out_vld_q <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q    <= c_d;
      g_q    <= g_d;
      j_q    <= j_d;
      l_q    <= l_d;
      sol_q  <= sol_d;
      sing_q <= l_q.sing;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DW'({sol_q[2], sol_q[1], sol_q[0]});
  assign m_axis_tuser  = sing_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular word with nonzero solution");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(c_vld_q) && $stable(g_vld_q) && $stable(l_vld_q))
    else $error("pipeline moved during stall");

  a_sing_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && l_vld_q && l_q.sing |=> m_axis_tvalid && m_axis_tuser)
    else $error("singular flag lost at output");

endmodule

`default_nettype wire
